// File: design/wsdf_pkg.sv
// ----------------------------------------------------------------------------
// wsdf_pkg
// Shared types and codes for the WebSocket deframer with payload unmasking.
// ----------------------------------------------------------------------------
package wsdf_pkg;

  localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
  localparam logic [1:0] KIND_EMPTY_END = 2'd1;
  localparam logic [1:0] KIND_CLOSE     = 2'd2;
  localparam logic [1:0] KIND_PING      = 2'd3;

  localparam logic [3:0] OP_CLOSE = 4'd8;
  localparam logic [3:0] OP_PING  = 4'd9;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  localparam int FIN_POS = 7;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic       frame_end;
    logic       message_end;
    logic [3:0] msg_opcode;
  } result_t;

endpackage

// File: design/wsdf_if.sv
// ----------------------------------------------------------------------------
// wsdf_if
// Valid/ready channels for the raw byte stream and for the deframed results.
// ----------------------------------------------------------------------------
interface wsdf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface wsdf_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] payload_byte;
  logic       frame_end;
  logic       message_end;
  logic [3:0] msg_opcode;

  modport source (output valid, output kind, output payload_byte, output frame_end,
                  output message_end, output msg_opcode, input ready);
  modport sink (input valid, input kind, input payload_byte, input frame_end,
                input message_end, input msg_opcode, output ready);
endinterface

// File: design/wsdf_parser.sv
// ----------------------------------------------------------------------------
// wsdf_parser
// Frame header parser and payload unmasker; handles one byte per enabled cycle.
// ----------------------------------------------------------------------------
module wsdf_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [7:0]        data,
  output logic              res_valid,
  output wsdf_pkg::result_t res
);
  import wsdf_pkg::*;

  logic [3:0]  header_index, header_index_next;
  logic [3:0]  header_size, header_size_next;
  logic [7:0]  message_flags, message_flags_next;
  logic        mask_present, mask_present_next;
  logic [6:0]  length_code, length_code_next;
  logic [63:0] frame_length, frame_length_next;
  logic [63:0] payload_count, payload_count_next;
  logic [7:0]  mask_key [4];
  logic [7:0]  mask_key_next [4];
  logic        in_payload, in_payload_next;
  logic        stopped, stopped_next;

  function automatic logic [3:0] ext_bytes(input logic [6:0] code);
    logic [3:0] n;
    n = 4'd0;
    if (code == LEN_CODE_16) n = 4'd2;
    else if (code == LEN_CODE_64) n = 4'd8;
    return n;
  endfunction

  logic [3:0]  ext;
  logic [3:0]  ext_end;
  logic [1:0]  key_off;
  logic [63:0] count_inc;
  logic        fend;
  logic [3:0]  op;

  always_comb begin
    header_index_next  = header_index;
    header_size_next   = header_size;
    message_flags_next = message_flags;
    mask_present_next  = mask_present;
    length_code_next   = length_code;
    frame_length_next  = frame_length;
    payload_count_next = payload_count;
    mask_key_next      = mask_key;
    in_payload_next    = in_payload;
    stopped_next       = stopped;
    res_valid          = 1'b0;
    res                = '0;
    res.msg_opcode     = message_flags[3:0];
    ext                = 4'd0;
    ext_end            = 4'd0;
    key_off            = 2'd0;
    count_inc          = payload_count + 64'd1;
    fend               = 1'b0;
    op                 = message_flags[3:0];

    if (en && !stopped) begin
      if (in_payload) begin
        fend               = (count_inc == frame_length);
        payload_count_next = count_inc;
        res_valid          = 1'b1;
        res.kind           = KIND_PAYLOAD;
        res.payload_byte   = mask_present ? (data ^ mask_key[payload_count[1:0]]) : data;
        res.frame_end      = fend;
        res.message_end    = fend & message_flags[FIN_POS];
        if (fend) begin
          in_payload_next   = 1'b0;
          header_index_next = 4'd0;
          if (message_flags[FIN_POS]) stopped_next = 1'b1;
        end
      end else if (header_index == 4'd0) begin
        if (data[3:0] != 4'd0) message_flags_next = data;
        else message_flags_next = {data[7:4], message_flags[3:0]};
        header_index_next = 4'd1;
      end else begin
        if (header_index == 4'd1) begin
          ext               = ext_bytes(data[6:0]);
          mask_present_next = data[7];
          length_code_next  = data[6:0];
          header_size_next  = 4'd2 + ext + (data[7] ? 4'd4 : 4'd0);
          frame_length_next = (data[6:0] < LEN_CODE_16) ? {57'd0, data[6:0]} : 64'd0;
        end else begin
          ext     = ext_bytes(length_code);
          ext_end = 4'd2 + ext;
          if (header_index < ext_end) begin
            frame_length_next = {frame_length[55:0], data};
          end else begin
            key_off = 2'(header_index - ext_end);
            mask_key_next[key_off] = data;
          end
        end
        if (({1'b0, header_index} + 5'd1) < {1'b0, header_size_next}) begin
          header_index_next = header_index + 4'd1;
        end else begin
          header_index_next  = 4'd0;
          payload_count_next = 64'd0;
          if (op == OP_CLOSE || op == OP_PING) begin
            frame_length_next = 64'd0;
            stopped_next      = 1'b1;
            res_valid         = 1'b1;
            res.kind          = (op == OP_CLOSE) ? KIND_CLOSE : KIND_PING;
          end else if (frame_length_next == 64'd0) begin
            res_valid       = 1'b1;
            res.kind        = KIND_EMPTY_END;
            res.frame_end   = 1'b1;
            res.message_end = message_flags[FIN_POS];
            in_payload_next = 1'b0;
            if (message_flags[FIN_POS]) stopped_next = 1'b1;
          end else begin
            in_payload_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_index  <= '0;
      header_size   <= '0;
      message_flags <= '0;
      mask_present  <= 1'b0;
      length_code   <= '0;
      frame_length  <= '0;
      payload_count <= '0;
      mask_key      <= '{default: '0};
      in_payload    <= 1'b0;
      stopped       <= 1'b0;
    end else begin
      header_index  <= header_index_next;
      header_size   <= header_size_next;
      message_flags <= message_flags_next;
      mask_present  <= mask_present_next;
      length_code   <= length_code_next;
      frame_length  <= frame_length_next;
      payload_count <= payload_count_next;
      mask_key      <= mask_key_next;
      in_payload    <= in_payload_next;
      stopped       <= stopped_next;
    end
  end

  a_stop_holds: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped)
    else $error("parser left the stopped state without reset");

  a_no_result_stopped: assert property (@(posedge clk) disable iff (rst)
    stopped |-> !res_valid)
    else $error("result produced while stopped");

  a_header_in_range: assert property (@(posedge clk) disable iff (rst)
    (!in_payload && header_index > 4'd1) |-> header_index < header_size)
    else $error("header index ran past the header size");

endmodule

// File: design/websocket_frame_deframer_unmask.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unmask
// An accepted byte is held in s1_byte; its parsed result goes to the output register.
// Throughput: one byte per cycle unless a held result waits on result.ready.
// Reset (rst, synchronous) returns the parser to the first header byte and
// clears the stopped state; a close, ping or completed final frame stops the
// block, and every later byte is taken and dropped until the next reset.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unmask (
  input  logic          clk,
  input  logic          rst,
  wsdf_byte_if.sink     stream,
  wsdf_result_if.source result
);
  import wsdf_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_advance;
  logic       out_valid;
  result_t    out_res;
  logic       res_valid;
  result_t    res;

  assign s1_advance   = !out_valid || result.ready;
  assign stream.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (stream.ready) begin
      s1_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.ready && stream.valid) begin
      s1_byte <= stream.in_byte;
    end
  end

  wsdf_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .en        (s1_valid && s1_advance),
    .data      (s1_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid && res_valid) begin
      out_res <= res;
    end
  end

  assign result.valid        = out_valid;
  assign result.kind         = out_res.kind;
  assign result.payload_byte = out_res.payload_byte;
  assign result.frame_end    = out_res.frame_end;
  assign result.message_end  = out_res.message_end;
  assign result.msg_opcode   = out_res.msg_opcode;

  a_msg_end_is_frame_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.message_end) |-> out_res.frame_end)
    else $error("message end without frame end");

  a_zero_byte_off_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.kind != KIND_PAYLOAD) |-> out_res.payload_byte == 8'd0)
    else $error("nonzero byte on a non-payload result");

  a_control_no_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_res.kind == KIND_CLOSE || out_res.kind == KIND_PING))
      |-> (!out_res.frame_end && !out_res.message_end))
    else $error("close or ping result marked as frame end");

  a_silent_after_stop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.ready && (out_res.message_end || out_res.kind == KIND_CLOSE
      || out_res.kind == KIND_PING)) |=> !out_valid)
    else $error("result produced after the block stopped");

endmodule
